// ===== rtl/esd_pkg.sv =====
package esd_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_CARET  = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_OCT    = 3'd4
    } t_mode;

    // one queue entry: the results caused by one input word
    typedef struct packed {
        logic       two;
        logic [7:0] v0;
        logic       bad0;
        logic [7:0] v1;
    } t_entry;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LO_A      = 8'h61;
    localparam logic [7:0] CH_LO_F      = 8'h66;
    localparam logic [7:0] CH_LO_Z      = 8'h7A;
    localparam logic [7:0] CH_UP_A      = 8'h41;
    localparam logic [7:0] CH_UP_F      = 8'h46;
    localparam logic [7:0] CH_UP_B      = 8'h42;
    localparam logic [7:0] CH_UP_E      = 8'h45;
    localparam logic [7:0] CH_UP_N      = 8'h4E;
    localparam logic [7:0] CH_UP_R      = 8'h52;
    localparam logic [7:0] CH_UP_S      = 8'h53;
    localparam logic [7:0] CH_UP_T      = 8'h54;
    localparam logic [7:0] CH_UP_X      = 8'h58;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] CODE_BS      = 8'h08;
    localparam logic [7:0] CODE_FF      = 8'h0C;
    localparam logic [7:0] CODE_LF      = 8'h0A;
    localparam logic [7:0] CODE_CR      = 8'h0D;
    localparam logic [7:0] CODE_SPACE   = 8'h20;
    localparam logic [7:0] CODE_TAB     = 8'h09;
    localparam logic [7:0] CODE_ESC     = 8'h1B;
    localparam logic [7:0] BAD_HEX_VAL  = 8'hFF;
    localparam logic [3:0] HEX_LETTER_ADJ = 4'd9;
    localparam logic [4:0] OCT_PREFIX   = 5'b00110;
    localparam logic [1:0] OCT_FULL     = 2'd3;

endpackage

// ===== rtl/esd_fifo.sv =====
module esd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/esd_front.sv =====
module esd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [7:0]     i_in_byte,
    input  logic           i_q_full,
    output logic           o_q_wr,
    output esd_pkg::t_entry o_q_entry
);

    esd_pkg::t_mode r_mode, n_mode;
    logic [7:0]     r_accum, n_accum;
    logic [1:0]     r_count, n_count;

    logic       accept;
    logic [7:0] c;
    logic [7:0] c_up;
    logic       is_dec, is_lo_hex, is_up_hex, is_hex, is_oct;
    logic [3:0] hex_d;
    logic [7:0] oct_acc;
    logic [1:0] oct_cnt;
    logic       emit;

    assign accept = i_push && !i_q_full;
    assign c      = i_in_byte;
    assign c_up   = (c >= esd_pkg::CH_LO_A && c <= esd_pkg::CH_LO_Z) ?
                    c - esd_pkg::CASE_OFFSET : c;

    assign is_dec    = (c >= esd_pkg::CH_ZERO && c <= esd_pkg::CH_NINE);
    assign is_lo_hex = (c >= esd_pkg::CH_LO_A && c <= esd_pkg::CH_LO_F);
    assign is_up_hex = (c >= esd_pkg::CH_UP_A && c <= esd_pkg::CH_UP_F);
    assign is_hex    = is_dec || is_lo_hex || is_up_hex;
    // letters a-f and A-F share low nibbles 1..6
    assign hex_d     = is_dec ? c[3:0] : c[3:0] + esd_pkg::HEX_LETTER_ADJ;
    assign is_oct    = (c[7:3] == esd_pkg::OCT_PREFIX);
    assign oct_acc   = {r_accum[4:0], c[2:0]};
    assign oct_cnt   = r_count + 2'd1;

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_accum = r_accum;
        n_count = r_count;
        unique case (r_mode)
            esd_pkg::MODE_NORMAL: begin
                n_mode = (c == esd_pkg::CH_BACKSLASH) ? esd_pkg::MODE_ESC
                                                      : esd_pkg::MODE_NORMAL;
            end
            esd_pkg::MODE_ESC: begin
                n_mode = esd_pkg::MODE_NORMAL;
                if (c_up == esd_pkg::CH_CARET) begin
                    n_mode = esd_pkg::MODE_CARET;
                end else if (c_up == esd_pkg::CH_UP_X) begin
                    n_mode  = esd_pkg::MODE_HEX;
                    n_accum = '0;
                    n_count = '0;
                end else if (is_oct) begin
                    n_mode  = esd_pkg::MODE_OCT;
                    n_accum = {5'd0, c[2:0]};
                    n_count = 2'd1;
                end
            end
            esd_pkg::MODE_CARET: begin
                n_mode = esd_pkg::MODE_NORMAL;
            end
            esd_pkg::MODE_HEX: begin
                if (is_hex) begin
                    if (r_count == 2'd0) begin
                        n_accum = {4'd0, hex_d};
                        n_count = 2'd1;
                    end else begin
                        n_mode  = esd_pkg::MODE_NORMAL;
                        n_count = '0;
                    end
                end else begin
                    n_count = '0;
                    n_mode  = (c == esd_pkg::CH_BACKSLASH) ? esd_pkg::MODE_ESC
                                                           : esd_pkg::MODE_NORMAL;
                end
            end
            esd_pkg::MODE_OCT: begin
                if (is_oct) begin
                    n_accum = oct_acc;
                    n_count = oct_cnt;
                    if (oct_cnt == esd_pkg::OCT_FULL) begin
                        n_mode  = esd_pkg::MODE_NORMAL;
                        n_count = '0;
                    end
                end else begin
                    n_count = '0;
                    n_mode  = (c == esd_pkg::CH_BACKSLASH) ? esd_pkg::MODE_ESC
                                                           : esd_pkg::MODE_NORMAL;
                end
            end
            default: begin
                n_mode = (c == esd_pkg::CH_BACKSLASH) ? esd_pkg::MODE_ESC
                                                      : esd_pkg::MODE_NORMAL;
            end
        endcase
    end

    // outputs: classify the word into zero, one or two results
    always_comb begin
        emit      = 1'b0;
        o_q_entry = '0;
        unique case (r_mode)
            esd_pkg::MODE_NORMAL: begin
                emit = (c != esd_pkg::CH_BACKSLASH);
                o_q_entry.v0 = c;
            end
            esd_pkg::MODE_ESC: begin
                emit = 1'b1;
                unique case (c_up) inside
                    esd_pkg::CH_NUL:   o_q_entry.v0 = esd_pkg::CH_BACKSLASH;
                    esd_pkg::CH_UP_B:  o_q_entry.v0 = esd_pkg::CODE_BS;
                    esd_pkg::CH_UP_F:  o_q_entry.v0 = esd_pkg::CODE_FF;
                    esd_pkg::CH_UP_N:  o_q_entry.v0 = esd_pkg::CODE_LF;
                    esd_pkg::CH_UP_R:  o_q_entry.v0 = esd_pkg::CODE_CR;
                    esd_pkg::CH_UP_S:  o_q_entry.v0 = esd_pkg::CODE_SPACE;
                    esd_pkg::CH_UP_T:  o_q_entry.v0 = esd_pkg::CODE_TAB;
                    esd_pkg::CH_UP_E:  o_q_entry.v0 = esd_pkg::CODE_ESC;
                    esd_pkg::CH_CARET, esd_pkg::CH_UP_X: emit = 1'b0;
                    default: begin
                        emit = !is_oct;
                        o_q_entry.v0 = c;
                    end
                endcase
            end
            esd_pkg::MODE_CARET: begin
                emit = 1'b1;
                o_q_entry.v0 = c_up - esd_pkg::CH_AT;
            end
            esd_pkg::MODE_HEX: begin
                if (is_hex) begin
                    emit = (r_count != 2'd0);
                    o_q_entry.v0 = {r_accum[3:0], hex_d};
                end else begin
                    emit = 1'b1;
                    o_q_entry.two = (c != esd_pkg::CH_BACKSLASH);
                    o_q_entry.v1  = c;
                    if (r_count == 2'd0) begin
                        o_q_entry.v0   = esd_pkg::BAD_HEX_VAL;
                        o_q_entry.bad0 = 1'b1;
                    end else begin
                        o_q_entry.v0 = r_accum;
                    end
                end
            end
            esd_pkg::MODE_OCT: begin
                if (is_oct) begin
                    emit = (oct_cnt == esd_pkg::OCT_FULL);
                    o_q_entry.v0 = oct_acc;
                end else begin
                    emit = 1'b1;
                    o_q_entry.v0  = r_accum;
                    o_q_entry.two = (c != esd_pkg::CH_BACKSLASH);
                    o_q_entry.v1  = c;
                end
            end
            default: begin
                emit = (c != esd_pkg::CH_BACKSLASH);
                o_q_entry.v0 = c;
            end
        endcase
    end

    assign o_q_wr = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= esd_pkg::MODE_NORMAL;
            r_accum <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/esd_back.sv =====
module esd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  esd_pkg::t_entry i_q_head,
    output logic            o_q_rd,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      o_out_byte,
    output logic            o_bad_hex,
    output logic            o_last_of_run
);

    logic       r_valid, n_valid;
    logic       r_slot, n_slot;
    logic [7:0] r_byte;
    logic       r_bad;
    logic       r_last;
    logic       load;

    // output register refills whenever it is free or being drained and the queue holds an entry
    assign load   = (!r_valid || pop) && !i_q_empty;
    assign o_q_rd = load && (r_slot || !i_q_head.two);

    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        if (load) begin
            n_valid = 1'b1;
            n_slot  = r_slot ? 1'b0 : i_q_head.two;
        end else if (pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_slot  <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= r_slot ? i_q_head.v1 : i_q_head.v0;
            r_bad  <= r_slot ? 1'b0 : i_q_head.bad0;
            r_last <= r_slot || !i_q_head.two;
        end
    end

    assign empty         = !r_valid;
    assign o_out_byte    = r_byte;
    assign o_bad_hex     = r_bad;
    assign o_last_of_run = r_last;

    a_slot_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot |-> !i_q_empty)
        else $error("second result pending with queue empty");

    a_slot_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot |-> i_q_head.two)
        else $error("second result pending for a single-result entry");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_valid)
        else $error("loaded result not shown");

    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_slot) |=> (r_last && !r_bad && !r_slot))
        else $error("second result not marked last");

endmodule

// ===== rtl/escape_sequence_decoder_core.sv =====
// path: a result is written to the entry queue and then loaded into the output register, which
// refills when free or popped; a second result from the same word is loaded when the first is popped
// throughput: one input word per cycle while the entry queue is not full; the output stage sends one
// result per cycle while popped, so a word giving two results waits at the head of the entry queue
// full rises only when the entry queue between front and back is full
// reset: synchronous active low; decoder returns to normal mode, queue and output empty
module escape_sequence_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_bad_hex,
    output logic       o_last_of_run
);

    esd_pkg::t_entry q_wr_entry;
    esd_pkg::t_entry q_head;
    logic            q_wr;
    logic            q_rd;
    logic            q_full;
    logic            q_empty;

    assign full = q_full;

    esd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_byte (i_in_byte),
        .i_q_full  (q_full),
        .o_q_wr    (q_wr),
        .o_q_entry (q_wr_entry)
    );

    esd_fifo #(
        .WIDTH ($bits(esd_pkg::t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_wr_entry),
        .i_rd    (q_rd),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    esd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_head      (q_head),
        .o_q_rd        (q_rd),
        .pop           (pop),
        .empty         (empty),
        .o_out_byte    (o_out_byte),
        .o_bad_hex     (o_bad_hex),
        .o_last_of_run (o_last_of_run)
    );

endmodule
